### src/uvsg_pkg.sv
// ----------------------------------------------------------------------------
// uvsg_pkg
// Shared types and constants of the UV-sphere vertex generator.
// ----------------------------------------------------------------------------
package uvsg_pkg;

  // Sizes of the sine table and the grid
  localparam int unsigned SINE_TABLE_DEPTH = 1024;
  localparam int unsigned MAX_GRID_INDEX   = 255;

  // Largest usable grid index for an 8-bit index field
  localparam logic [7:0] GRID_CAP =
    (MAX_GRID_INDEX > 255) ? 8'd255 : 8'(MAX_GRID_INDEX);

  // 1.0 in Q16 texture units
  localparam logic [16:0] TEX_ONE = 17'd65536;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HORIZ_STEP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VERT_STEP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_U_STEP       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_V_STEP       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPHERE_RADIUS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SKYBOX_MODE  = 3'd5;

  // Register reset values
  localparam logic [15:0] RST_HORIZ_STEP    = 16'd4096;
  localparam logic [15:0] RST_VERT_STEP     = 16'd2048;
  localparam logic [16:0] RST_U_STEP        = 17'd4096;
  localparam logic [16:0] RST_V_STEP        = 17'd4096;
  localparam logic [14:0] RST_SPHERE_RADIUS = 15'd256;
  localparam logic        RST_SKYBOX_MODE   = 1'b0;

  // Configuration register set
  typedef struct packed {
    logic [15:0] horiz_step;
    logic [15:0] vert_step;
    logic [16:0] u_step;
    logic [16:0] v_step;
    logic [14:0] sphere_radius;
    logic        skybox_mode;
  } cfg_t;

  // Input item
  typedef struct packed {
    logic [7:0] ring_index;
    logic [7:0] slice_index;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic        [16:0] tex_u;
    logic        [16:0] tex_v;
  } out_item_t;

  // Sine and cosine of one phase as Q1.15 magnitude plus sign
  typedef struct packed {
    logic [15:0] sin_mag;
    logic        sin_neg;
    logic [15:0] cos_mag;
    logic        cos_neg;
  } trig_t;

endpackage

### src/uvsg_cfg_regs.sv
// ----------------------------------------------------------------------------
// uvsg_cfg_regs
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module uvsg_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [uvsg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [uvsg_pkg::CFG_DATA_W-1:0]     cfg_data,
  output uvsg_pkg::cfg_t                      cfg
);

  uvsg_pkg::cfg_t cfg_r;
  uvsg_pkg::cfg_t cfg_nxt;

  // Always able to take a write
  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // Decode the write
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        uvsg_pkg::CFG_HORIZ_STEP:    cfg_nxt.horiz_step    = cfg_data[15:0];
        uvsg_pkg::CFG_VERT_STEP:     cfg_nxt.vert_step     = cfg_data[15:0];
        uvsg_pkg::CFG_U_STEP:        cfg_nxt.u_step        = cfg_data[16:0];
        uvsg_pkg::CFG_V_STEP:        cfg_nxt.v_step        = cfg_data[16:0];
        uvsg_pkg::CFG_SPHERE_RADIUS: cfg_nxt.sphere_radius = cfg_data[14:0];
        uvsg_pkg::CFG_SKYBOX_MODE:   cfg_nxt.skybox_mode   = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.horiz_step    <= uvsg_pkg::RST_HORIZ_STEP;
      cfg_r.vert_step     <= uvsg_pkg::RST_VERT_STEP;
      cfg_r.u_step        <= uvsg_pkg::RST_U_STEP;
      cfg_r.v_step        <= uvsg_pkg::RST_V_STEP;
      cfg_r.sphere_radius <= uvsg_pkg::RST_SPHERE_RADIUS;
      cfg_r.skybox_mode   <= uvsg_pkg::RST_SKYBOX_MODE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### src/uvsg_sine_rom.sv
// ----------------------------------------------------------------------------
// uvsg_sine_rom
// Quarter-wave sine ROM, Q1.15 entries 0..DEPTH, registered read.
// ----------------------------------------------------------------------------
module uvsg_sine_rom #(
  parameter int unsigned DEPTH = uvsg_pkg::SINE_TABLE_DEPTH
) (
  input  logic                       clk,
  input  logic [$clog2(DEPTH+1)-1:0] rd_addr,
  output logic [15:0]                rd_data
);

  localparam int unsigned ADDR_W = $clog2(DEPTH + 1);
  // pi/2 in Q30
  localparam longint unsigned PHQ30 = 64'd1686629713;
  // Taylor divisors (2n)(2n+1) for n = 1..8
  localparam longint unsigned SERIES_DIV [8] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
  };

  typedef logic [15:0] rom_arr_t [0:DEPTH];

  // Build the table at elaboration with a Q30 Taylor series
  function automatic rom_arr_t build_rom();
    rom_arr_t        tab;
    longint unsigned th;
    longint unsigned t2;
    longint unsigned term;
    longint unsigned sum;
    longint unsigned rnd;
    for (int i = 0; i <= int'(DEPTH); i++) begin
      th   = (PHQ30 * 64'(i)) / DEPTH;
      t2   = (th * th) >> 30;
      term = th;
      sum  = th;
      for (int n = 0; n < 8; n++) begin
        term = ((term * t2) >> 30) / SERIES_DIV[n];
        if ((n & 1) == 0) begin
          sum = (sum >= term) ? sum - term : 64'd0;
        end else begin
          sum = sum + term;
        end
      end
      rnd = (sum + 64'd16384) >> 15;
      if (rnd > 64'd32768) begin
        rnd = 64'd32768;
      end
      tab[i] = rnd[15:0];
    end
    return tab;
  endfunction

  localparam rom_arr_t ROM_TABLE = build_rom();

  logic [15:0] rd_data_r;

  always_ff @(posedge clk) begin
    rd_data_r <= ROM_TABLE[rd_addr[ADDR_W-1:0]];
  end

  assign rd_data = rd_data_r;

endmodule

### src/uvsg_trig.sv
// ----------------------------------------------------------------------------
// uvsg_trig
// Sine and cosine of a 16-bit phase: address stage, then ROM read stage.
// ----------------------------------------------------------------------------
module uvsg_trig #(
  parameter int unsigned DEPTH = uvsg_pkg::SINE_TABLE_DEPTH
) (
  input  logic            clk,
  input  logic [15:0]     phase,
  output uvsg_pkg::trig_t trig
);

  localparam int unsigned ADDR_W = $clog2(DEPTH + 1);
  localparam logic [ADDR_W-1:0] DEPTH_V = ADDR_W'(DEPTH);

  logic [ADDR_W+13:0] k_prod;
  logic [ADDR_W-1:0]  k;
  logic [ADDR_W-1:0]  addr_sin_nxt;
  logic [ADDR_W-1:0]  addr_cos_nxt;
  logic [ADDR_W-1:0]  addr_sin_r;
  logic [ADDR_W-1:0]  addr_cos_r;
  logic               neg_sin_r;
  logic               neg_cos_r;
  logic               neg_sin_d_r;
  logic               neg_cos_d_r;
  logic [15:0]        sin_mag;
  logic [15:0]        cos_mag;

  // Table index from the in-quadrant offset; cosine shares it one quadrant on
  assign k_prod       = {{ADDR_W{1'b0}}, phase[13:0]} * {14'b0, DEPTH_V};
  assign k            = k_prod[ADDR_W+13:14];
  assign addr_sin_nxt = phase[14] ? (DEPTH_V - k) : k;
  assign addr_cos_nxt = phase[14] ? k : (DEPTH_V - k);

  // Address stage
  always_ff @(posedge clk) begin
    addr_sin_r <= addr_sin_nxt;
    addr_cos_r <= addr_cos_nxt;
    neg_sin_r  <= phase[15];
    neg_cos_r  <= phase[15] ^ phase[14];
  end

  // Read stage
  uvsg_sine_rom #(.DEPTH(DEPTH)) u_rom_sin (
    .clk     (clk),
    .rd_addr (addr_sin_r),
    .rd_data (sin_mag)
  );

  uvsg_sine_rom #(.DEPTH(DEPTH)) u_rom_cos (
    .clk     (clk),
    .rd_addr (addr_cos_r),
    .rd_data (cos_mag)
  );

  always_ff @(posedge clk) begin
    neg_sin_d_r <= neg_sin_r;
    neg_cos_d_r <= neg_cos_r;
  end

  assign trig.sin_mag = sin_mag;
  assign trig.sin_neg = neg_sin_d_r;
  assign trig.cos_mag = cos_mag;
  assign trig.cos_neg = neg_cos_d_r;

endmodule

### src/uvsg_vertex_math.sv
// ----------------------------------------------------------------------------
// uvsg_vertex_math
// Radius scaling of the vertex: two multiply stages, then round, saturate and
// drive the result register.
// ----------------------------------------------------------------------------
module uvsg_vertex_math (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  uvsg_pkg::trig_t     pol,
  input  uvsg_pkg::trig_t     az,
  input  logic [16:0]         tex_u,
  input  logic [16:0]         tex_v,
  input  logic [14:0]         sphere_radius,
  input  logic                skybox_mode,
  output logic                out_valid,
  output uvsg_pkg::out_item_t out_data
);

  // Magnitude to signed 16 bits with saturation
  function automatic logic signed [15:0] sat16(input logic [16:0] mag, input logic neg);
    logic [16:0] capped;
    if (neg) begin
      capped = (mag > 17'd32768) ? 17'd32768 : mag;
      sat16  = 16'(17'd0 - capped);
    end else begin
      capped = (mag > 17'd32767) ? 17'd32767 : mag;
      sat16  = capped[15:0];
    end
  endfunction

  logic [15:0] fx_mag;
  logic        fx_neg;
  logic [15:0] fz_mag;
  logic        fz_neg;
  logic [31:0] mx_full;
  logic [31:0] mz_full;
  logic [30:0] my_full;

  logic        valid_e_r;
  logic [30:0] mx_e_r;
  logic [30:0] mz_e_r;
  logic [30:0] my_e_r;
  logic        x_neg_e_r;
  logic        y_neg_e_r;
  logic        z_neg_e_r;
  logic [16:0] tex_u_e_r;
  logic [16:0] tex_v_e_r;

  logic        valid_f_r;
  logic [45:0] px_f_r;
  logic [45:0] pz_f_r;
  logic [30:0] my_f_r;
  logic        x_neg_f_r;
  logic        y_neg_f_r;
  logic        z_neg_f_r;
  logic [16:0] tex_u_f_r;
  logic [16:0] tex_v_f_r;

  logic [46:0] rx_sum;
  logic [46:0] rz_sum;
  logic [31:0] ry_sum;

  logic                valid_g_r;
  uvsg_pkg::out_item_t out_data_r;
  uvsg_pkg::out_item_t out_data_nxt;

  // Skybox swaps the azimuth sine and cosine
  assign fx_mag  = skybox_mode ? az.cos_mag : az.sin_mag;
  assign fx_neg  = skybox_mode ? az.cos_neg : az.sin_neg;
  assign fz_mag  = skybox_mode ? az.sin_mag : az.cos_mag;
  assign fz_neg  = skybox_mode ? az.sin_neg : az.cos_neg;
  assign mx_full = fx_mag * pol.sin_mag;
  assign mz_full = fz_mag * pol.sin_mag;
  assign my_full = {15'b0, pol.cos_mag} * {16'b0, sphere_radius};

  // Stage E: azimuth times polar sine, polar cosine times radius
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_e_r <= 1'b0;
    end else begin
      valid_e_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    mx_e_r    <= mx_full[30:0];
    mz_e_r    <= mz_full[30:0];
    my_e_r    <= my_full;
    x_neg_e_r <= fx_neg ^ pol.sin_neg;
    z_neg_e_r <= fz_neg ^ pol.sin_neg;
    y_neg_e_r <= pol.cos_neg;
    tex_u_e_r <= tex_u;
    tex_v_e_r <= tex_v;
  end

  // Stage F: times radius
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_f_r <= 1'b0;
    end else begin
      valid_f_r <= valid_e_r;
    end
  end

  always_ff @(posedge clk) begin
    px_f_r    <= {15'b0, mx_e_r} * {31'b0, sphere_radius};
    pz_f_r    <= {15'b0, mz_e_r} * {31'b0, sphere_radius};
    my_f_r    <= my_e_r;
    x_neg_f_r <= x_neg_e_r;
    y_neg_f_r <= y_neg_e_r;
    z_neg_f_r <= z_neg_e_r;
    tex_u_f_r <= tex_u_e_r;
    tex_v_f_r <= tex_v_e_r;
  end

  // Stage G: round half away from zero on magnitudes, then saturate
  assign rx_sum = {1'b0, px_f_r} + 47'(64'd1 << 29);
  assign rz_sum = {1'b0, pz_f_r} + 47'(64'd1 << 29);
  assign ry_sum = {1'b0, my_f_r} + 32'd16384;

  always_comb begin
    out_data_nxt.pos_x = sat16(rx_sum[46:30], x_neg_f_r);
    out_data_nxt.pos_y = sat16(ry_sum[31:15], y_neg_f_r);
    out_data_nxt.pos_z = sat16(rz_sum[46:30], z_neg_f_r);
    out_data_nxt.tex_u = tex_u_f_r;
    out_data_nxt.tex_v = tex_v_f_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_g_r <= 1'b0;
    end else begin
      valid_g_r <= valid_f_r;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = valid_g_r;
  assign out_data  = out_data_r;

endmodule

### src/uv_sphere_vertex_generator.sv
// Throughput: one item per cycle; busy stays low, every cycle can take a start.
// Path: input reg, phase multiply, ROM address, ROM read, two multiply stages,
//   round/saturate into the result register.
// Reset: synchronous active-low rst_n clears the valid bits and loads the
//   register defaults; no clearing pass, the sine table is a constant ROM.
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator
// Grid point (ring, slice) to UV-sphere vertex and texture coordinates.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_generator #(
  parameter int unsigned SINE_TABLE_DEPTH = uvsg_pkg::SINE_TABLE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input items
  input  logic                             start,
  output logic                             busy,
  input  uvsg_pkg::in_item_t               in_data,
  // results
  output logic                             out_valid,
  output uvsg_pkg::out_item_t              out_data,
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [uvsg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [uvsg_pkg::CFG_DATA_W-1:0]  cfg_data
);

  uvsg_pkg::cfg_t  cfg;
  logic            in_accept;

  logic            valid_a_r;
  logic [7:0]      ring_a_r;
  logic [7:0]      slice_a_r;

  logic [23:0]     pol_prod;
  logic [23:0]     az_prod;
  logic [24:0]     u_prod;
  logic [24:0]     v_prod;

  logic            valid_b_r;
  logic [15:0]     pol_b_r;
  logic [15:0]     az_b_r;
  logic [24:0]     u_prod_b_r;
  logic [24:0]     v_prod_b_r;

  logic            valid_c_r;
  logic [16:0]     tex_u_c_r;
  logic [16:0]     tex_v_c_r;
  logic [16:0]     tex_u_nxt;
  logic [16:0]     tex_v_nxt;

  logic            valid_d_r;
  logic [16:0]     tex_u_d_r;
  logic [16:0]     tex_v_d_r;

  uvsg_pkg::trig_t pol_trig;
  uvsg_pkg::trig_t az_trig;

  // Pipeline never stalls
  assign busy      = 1'b0;
  assign in_accept = start && !busy;

  uvsg_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Stage A: capture the grid point, clamped to the grid limit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
    end else begin
      valid_a_r <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    ring_a_r  <= (in_data.ring_index > uvsg_pkg::GRID_CAP) ?
                 uvsg_pkg::GRID_CAP : in_data.ring_index;
    slice_a_r <= (in_data.slice_index > uvsg_pkg::GRID_CAP) ?
                 uvsg_pkg::GRID_CAP : in_data.slice_index;
  end

  // Stage B: phases (wrap to 16 bits) and texture products
  assign pol_prod = {16'b0, ring_a_r} * {8'b0, cfg.vert_step};
  assign az_prod  = {16'b0, slice_a_r} * {8'b0, cfg.horiz_step};
  assign u_prod   = {17'b0, slice_a_r} * {8'b0, cfg.u_step};
  assign v_prod   = {17'b0, ring_a_r} * {8'b0, cfg.v_step};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_b_r <= 1'b0;
    end else begin
      valid_b_r <= valid_a_r;
    end
  end

  always_ff @(posedge clk) begin
    pol_b_r    <= pol_prod[15:0];
    az_b_r     <= az_prod[15:0];
    u_prod_b_r <= u_prod;
    v_prod_b_r <= v_prod;
  end

  // Stages C and D of the trig path
  uvsg_trig #(.DEPTH(SINE_TABLE_DEPTH)) u_trig_pol (
    .clk   (clk),
    .phase (pol_b_r),
    .trig  (pol_trig)
  );

  uvsg_trig #(.DEPTH(SINE_TABLE_DEPTH)) u_trig_az (
    .clk   (clk),
    .phase (az_b_r),
    .trig  (az_trig)
  );

  // Stage C: texture floor and cap
  assign tex_u_nxt = (u_prod_b_r >= {8'b0, uvsg_pkg::TEX_ONE}) ? 17'd0 :
                     17'({8'b0, uvsg_pkg::TEX_ONE} - u_prod_b_r);
  assign tex_v_nxt = (v_prod_b_r > {8'b0, uvsg_pkg::TEX_ONE}) ? uvsg_pkg::TEX_ONE :
                     v_prod_b_r[16:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_c_r <= 1'b0;
      valid_d_r <= 1'b0;
    end else begin
      valid_c_r <= valid_b_r;
      valid_d_r <= valid_c_r;
    end
  end

  // Texture rides alongside the ROM stages
  always_ff @(posedge clk) begin
    tex_u_c_r <= tex_u_nxt;
    tex_v_c_r <= tex_v_nxt;
    tex_u_d_r <= tex_u_c_r;
    tex_v_d_r <= tex_v_c_r;
  end

  // Stages E to G
  uvsg_vertex_math u_vertex_math (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (valid_d_r),
    .pol           (pol_trig),
    .az            (az_trig),
    .tex_u         (tex_u_d_r),
    .tex_v         (tex_v_d_r),
    .sphere_radius (cfg.sphere_radius),
    .skybox_mode   (cfg.skybox_mode),
    .out_valid     (out_valid),
    .out_data      (out_data)
  );

`ifndef SYNTHESIS
  // Every result follows an item that was accepted earlier
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 7))
    else $error("result without matching accepted item");

  // Texture u never exceeds 1.0
  a_tex_u_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.tex_u <= uvsg_pkg::TEX_ONE))
    else $error("tex_u above one");

  // Texture v capped at 1.0
  a_tex_v_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.tex_v <= uvsg_pkg::TEX_ONE))
    else $error("tex_v above one");
`endif

endmodule
